// ===== hw/rtl/uva_pkg.sv =====
// Shared constants and types for the unit-vector autocorrelator.
package uva_pkg;

  localparam int NUM_LAGS    = 64;
  localparam int MAX_SAMPLES = 65536;
  localparam int COMP_BITS   = 16;

  localparam int LAG_BITS  = 6;
  localparam int CNT_BITS  = 17;
  localparam int SUM_BITS  = 49;
  localparam int DOT_BITS  = 33;
  localparam int UNIT_BITS = 16;
  localparam int CFG_BITS  = 7;

  typedef logic signed [UNIT_BITS-1:0] unit_t;

  typedef struct packed {
    unit_t ux;
    unit_t uy;
    unit_t uz;
  } uvec_t;

  // Cell control: accumulate a new unit vector, or clear the row.
  typedef struct packed {
    logic  acc;
    logic  clr;
    uvec_t u;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/uva_norm.sv =====
// Normalization unit: square sum, bit-serial square root, per-component division.
module uva_norm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [15:0]           cx,
  input  logic signed [15:0]           cy,
  input  logic signed [15:0]           cz,
  output logic                         done,
  output uva_pkg::uvec_t               u
);
  import uva_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state;
  logic [5:0]  step;
  logic [1:0]  comp;
  logic [15:0] mag [3];
  logic [2:0]  neg;
  logic [33:0] sq;
  logic [49:0] rem;
  logic [49:0] rad;
  logic [24:0] root;
  logic [38:0] dnum;
  logic [25:0] drem;
  logic [23:0] quo;
  logic [15:0] res [3];

  logic [51:0] trial;
  logic [26:0] dtrial;
  logic [15:0] sat;

  assign trial  = {rem, rad[49:48]} - {24'd0, root, 2'b01};
  assign dtrial = {drem, dnum[38]} - {2'd0, root};
  assign sat    = (quo > 24'd32767) ? 16'd32767 : quo[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            mag[0] <= cx[15] ? 16'(-cx) : 16'(cx);
            mag[1] <= cy[15] ? 16'(-cy) : 16'(cy);
            mag[2] <= cz[15] ? 16'(-cz) : 16'(cz);
            neg    <= {cz[15], cy[15], cx[15]};
            sq     <= 34'd0;
            comp   <= 2'd0;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          sq <= sq + 34'(32'(mag[comp]) * 32'(mag[comp]));
          if (comp == 2'd2) begin
            state <= S_SQRT;
            step  <= 6'd0;
            rem   <= 50'd0;
            root  <= 25'd0;
          end else begin
            comp <= comp + 2'd1;
          end
          if (comp == 2'd2) rad <= {sq + 34'(32'(mag[comp]) * 32'(mag[comp])), 16'd0};
        end
        S_SQRT: begin
          rad <= {rad[47:0], 2'b00};
          if (!trial[51]) begin
            rem  <= trial[49:0];
            root <= {root[23:0], 1'b1};
          end else begin
            rem  <= {rem[47:0], rad[49:48]};
            root <= {root[23:0], 1'b0};
          end
          if (step == 6'd24) begin
            state <= S_DIV;
            comp  <= 2'd0;
            step  <= 6'd0;
            dnum  <= {mag[0], 23'd0};
            drem  <= 26'd0;
          end else begin
            step <= step + 6'd1;
          end
        end
        S_DIV: begin
          if (step == 6'd39) begin
            res[comp] <= (root == 25'd0) ? 16'd0 : sat;
            step <= 6'd0;
            drem <= 26'd0;
            quo  <= 24'd0;
            if (comp == 2'd2) begin
              state <= S_DONE;
            end else begin
              comp <= comp + 2'd1;
              dnum <= {mag[comp + 2'd1], 23'd0};
            end
          end else begin
            dnum <= {dnum[37:0], 1'b0};
            if (!dtrial[26]) begin
              drem <= dtrial[25:0];
              quo  <= {quo[22:0], 1'b1};
            end else begin
              drem <= {drem[24:0], dnum[38]};
              quo  <= {quo[22:0], 1'b0};
            end
            step <= step + 6'd1;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done = (state == S_DONE);
  assign u.ux = neg[0] ? -$signed(res[0]) : $signed(res[0]);
  assign u.uy = neg[1] ? -$signed(res[1]) : $signed(res[1]);
  assign u.uz = neg[2] ? -$signed(res[2]) : $signed(res[2]);

endmodule

// ===== hw/rtl/uva_cell.sv =====
// One lag cell: holds a delayed unit vector and its running dot-product sum.
module uva_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  uva_pkg::cell_ctl_t   ctl,
  input  logic                 en,
  input  uva_pkg::uvec_t       hist_in,
  output uva_pkg::uvec_t       hist_out,
  input  logic                 shift,
  input  logic signed [48:0]   sum_in,
  output logic signed [48:0]   sum_out
);
  import uva_pkg::*;

  uvec_t              hist;
  logic signed [48:0] sum;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  logic signed [32:0] dot;

  assign px  = ctl.u.ux * hist_in.ux;
  assign py  = ctl.u.uy * hist_in.uy;
  assign pz  = ctl.u.uz * hist_in.uz;
  assign dot = 33'(px) + 33'(py) + 33'(pz);

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      hist <= '0;
      sum  <= '0;
    end else if (ctl.acc) begin
      hist <= hist_in;
      if (en) sum <= sum + 49'(dot);
    end else if (shift) begin
      sum <= sum_in;
    end
  end

  assign hist_out = hist;
  assign sum_out  = sum;

endmodule

// ===== hw/rtl/uva_mean.sv =====
// Emission divider: rounded sum / (n * 2^15), saturated to Q1.15.
module uva_mean (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [48:0]  sum,
  input  logic [16:0]         n,
  output logic                done,
  output logic signed [15:0]  corr
);
  import uva_pkg::*;

  logic        busy;
  logic [5:0]  step;
  logic        neg;
  logic        zero;
  logic [48:0] num;
  logic [32:0] den;
  logic [33:0] rem;
  logic [33:0] quo;
  logic [48:0] mag;
  logic [34:0] trial;

  assign mag   = sum[48] ? 49'(-sum) : 49'(sum);
  assign trial = {rem, num[48]} - {2'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (step == 6'd48);
      if (start) begin
        busy <= 1'b1;
        step <= 6'd0;
        neg  <= sum[48];
        zero <= (n == 17'd0);
        num  <= mag + 49'({n, 14'd0});
        den  <= {n, 15'd0};
        rem  <= 34'd0;
        quo  <= 34'd0;
      end else if (busy) begin
        num <= {num[47:0], 1'b0};
        if (!trial[34]) begin
          rem <= trial[33:0];
          quo <= {quo[32:0], 1'b1};
        end else begin
          rem <= {rem[32:0], num[48]};
          quo <= {quo[32:0], 1'b0};
        end
        if (step == 6'd48) begin
          busy <= 1'b0;
        end else begin
          step <= step + 6'd1;
        end
      end
    end
  end

  always_comb begin
    if (zero) begin
      corr = '0;
    end else if (neg) begin
      corr = (quo > 34'd32768) ? -16'sd32768 : -$signed(quo[15:0]);
    end else begin
      corr = (quo > 34'd32767) ? 16'sd32767 : $signed(quo[15:0]);
    end
  end

endmodule

// ===== hw/rtl/unit_vector_autocorrelator.sv =====
// Top level of the unit-vector autocorrelator.
// Input words on s_axis: one 3-D vector per word, tlast marks the end of a series.
// Each vector is normalized, then a row of 64 lag cells adds the dot product with
// the vector lag samples earlier, all lags in the same cycle. On the last word the
// cell sums shift out one by one through a serial divider and leave on m_axis with
// tuser = lag, tlast on the final lag; the row then clears. The block takes no new
// vector until the last one is accumulated; the pace is set by the serial square
// root and the three divisions of the normalizer, and a series end adds a division
// per emitted lag plus a clear state. A word past a full series is dropped.
// cfg sets lags_in_use (0 acts as 1, above 64 as 64); write it only while idle.
// Reset empties the row, zeroes the count and sets lags_in_use to 64.
// A stalled m_axis holds the result word; the block waits until it is taken.
module unit_vector_autocorrelator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // comp_x, comp_y, comp_z
  input  logic        s_axis_tlast,   // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // correlation
  output logic [5:0]  m_axis_tuser,   // lag_index
  output logic        m_axis_tlast,   // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  import uva_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  logic [2:0]          state;
  logic [6:0]          lags_in_use;
  logic [16:0]         count;
  logic                last;
  logic                full;
  logic [5:0]          lag;
  logic [6:0]          nlags;
  logic                norm_done;
  uvec_t               unit;
  cell_ctl_t           ctl;
  logic                shift;
  logic                div_start;
  logic                div_done;
  logic signed [15:0]  corr;
  logic [16:0]         div_n;

  uvec_t              hist [NUM_LAGS+1];
  logic signed [48:0] sums [NUM_LAGS+1];

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign full          = (count == 17'(MAX_SAMPLES));
  assign nlags = (lags_in_use == 7'd0) ? 7'd1 :
                 (lags_in_use > 7'(NUM_LAGS)) ? 7'(NUM_LAGS) : lags_in_use;

  uva_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (s_axis_tvalid && s_axis_tready && !full),
    .cx    (s_axis_tdata[15:0]),
    .cy    (s_axis_tdata[31:16]),
    .cz    (s_axis_tdata[47:32]),
    .done  (norm_done),
    .u     (unit)
  );

  assign ctl.acc = (state == S_ACC);
  assign ctl.clr = (state == S_CLR);
  assign ctl.u   = unit;
  assign shift   = div_start;
  assign hist[0] = unit;
  assign sums[NUM_LAGS] = '0;

  for (genvar g = 0; g < NUM_LAGS; g++) begin : g_cell
    uva_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .en       ({11'd0, 6'(g)} < count + 17'd1),
      .hist_in  (hist[g]),
      .hist_out (hist[g+1]),
      .shift    (shift),
      .sum_in   (sums[g+1]),
      .sum_out  (sums[g])
    );
  end

  assign div_n = (count > {11'd0, lag}) ? count - {11'd0, lag} : 17'd0;

  uva_mean u_mean (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (sums[0]),
    .n     (div_n),
    .done  (div_done),
    .corr  (corr)
  );

  assign div_start = (state == S_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      lags_in_use   <= 7'd64;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) lags_in_use <= cfg_data;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            last <= s_axis_tlast;
            lag  <= '0;
            if (!full) state <= S_NORM;
            else if (s_axis_tlast) state <= S_DIV;
          end
        end
        S_NORM: if (norm_done) state <= S_ACC;
        S_ACC: begin
          count <= count + 17'd1;
          state <= last ? S_DIV : S_IDLE;
        end
        S_DIV: state <= S_OUT;
        S_OUT: begin
          if (div_done) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= corr;
            m_axis_tuser  <= lag;
            m_axis_tlast  <= ({1'b0, lag} == nlags - 7'd1);
          end
          if (m_axis_tvalid && m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) begin
              state <= S_CLR;
            end else begin
              lag   <= lag + 6'd1;
              state <= S_DIV;
            end
          end
        end
        S_CLR: begin
          count <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
